### rtl/msrf_pkg.sv
// shared constants, codes and result type for the rx fanout buffer
package msrf_pkg;

  localparam int OP_W      = 3;
  localparam int TRANS_W   = 2;
  localparam int SESSION_W = 32;
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 11;
  localparam int DROP_W    = 32;

  localparam int RING_DEPTH_DEF = 1024;
  localparam int SLOT_COUNT_DEF = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_RX     = 3'd0;
  localparam logic [OP_W-1:0] OP_OPEN   = 3'd1;
  localparam logic [OP_W-1:0] OP_CLOSE  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_ACQ    = 3'd4;
  localparam logic [OP_W-1:0] OP_STATUS = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNAUTH  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STALE   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OWNER   = 3'd5;

  // the network transport needs authentication to open
  localparam logic [TRANS_W-1:0] NET_SLOT = 2'd1;

  typedef struct packed {
    logic [STATUS_W-1:0]  status_code;
    logic [SESSION_W-1:0] granted_id;
    logic [BYTE_W-1:0]    data_byte;
    logic                 data_valid;
    logic [COUNT_W-1:0]   buffered_count;
    logic [DROP_W-1:0]    dropped_count;
    logic                 is_tx_owner;
  } result_t;

endpackage

### rtl/msrf_if.sv
// request and result channel interfaces

interface msrf_in_if;
  import msrf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [TRANS_W-1:0]   transport;
  logic [SESSION_W-1:0] session;
  logic                 authenticated;
  logic [BYTE_W-1:0]    rx_byte;

  modport source (output valid, op, transport, session, authenticated, rx_byte,
                  input ready);
  modport sink (input valid, op, transport, session, authenticated, rx_byte,
                output ready);
endinterface

interface msrf_out_if;
  import msrf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status_code;
  logic [SESSION_W-1:0] granted_id;
  logic [BYTE_W-1:0]    data_byte;
  logic                 data_valid;
  logic [COUNT_W-1:0]   buffered_count;
  logic [DROP_W-1:0]    dropped_count;
  logic                 is_tx_owner;

  modport source (output valid, status_code, granted_id, data_byte, data_valid,
                  buffered_count, dropped_count, is_tx_owner,
                  input ready);
  modport sink (input valid, status_code, granted_id, data_byte, data_valid,
                buffered_count, dropped_count, is_tx_owner,
                output ready);
endinterface

### rtl/msrf_ram.sv
// generic single-port ram with registered read
module msrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/multi_subscriber_rx_fanout_buffer.sv
// rx fanout buffer: per-transport session slots sharing one byte ring memory
// open, close, acquire, status and errors: result registered, valid in the cycle after acceptance
// read of a non-empty ring: the registered ring memory output is loaded into the result register in S_RDATA
// rx byte: S_FAN visits every slot in turn, writing each open ring with room through the single memory port
// sync reset closes every slot, drops ownership and sets the id counter to one; no clearing pass
module multi_subscriber_rx_fanout_buffer #(
  parameter int RING_DEPTH = msrf_pkg::RING_DEPTH_DEF,
  parameter int SLOT_COUNT = msrf_pkg::SLOT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  msrf_in_if.sink    in_chan,
  msrf_out_if.source out_chan
);
  import msrf_pkg::*;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int HEAD_W = $clog2(RING_DEPTH);
  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int MEM_DEPTH = SLOT_COUNT * RING_DEPTH;
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FAN   = 2'd1;
  localparam logic [1:0] S_RDATA = 2'd2;

  // slot table, one lane per transport
  logic [SESSION_W-1:0] slot_id_r  [SLOT_COUNT];
  logic [SESSION_W-1:0] slot_id_nxt[SLOT_COUNT];
  logic [HEAD_W-1:0]    head_r     [SLOT_COUNT];
  logic [HEAD_W-1:0]    head_nxt   [SLOT_COUNT];
  logic [FILL_W-1:0]    fill_r     [SLOT_COUNT];
  logic [FILL_W-1:0]    fill_nxt   [SLOT_COUNT];
  logic [DROP_W-1:0]    drop_r     [SLOT_COUNT];
  logic [DROP_W-1:0]    drop_nxt   [SLOT_COUNT];

  logic [1:0]           state_r, state_nxt;
  logic [SLOT_W-1:0]    fan_idx_r, fan_idx_nxt;
  logic [BYTE_W-1:0]    byte_r, byte_nxt;
  logic [SESSION_W-1:0] id_ctr_r, id_ctr_nxt;
  logic                 owner_valid_r, owner_valid_nxt;
  logic [SLOT_W-1:0]    owner_slot_r, owner_slot_nxt;
  logic [SESSION_W-1:0] owner_id_r, owner_id_nxt;
  logic                 out_valid_r, out_valid_nxt;
  result_t              res_r, res_nxt;

  // ring memory port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [BYTE_W-1:0] ram_rdata;

  logic              in_fire;
  logic              out_take;
  logic              tr_ok;
  logic [SLOT_W-1:0] sidx;
  logic              owns;
  logic              load_out;
  result_t           res;

  // ring entry address of a slot; pos stays below RING_DEPTH
  function automatic logic [ADDR_W-1:0] ring_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [HEAD_W-1:0] pos);
    ring_addr = ADDR_W'(s) * ADDR_W'(RING_DEPTH) + ADDR_W'(pos);
  endfunction

  // head plus fill modulo ring depth, fill known to be below the depth
  function automatic logic [HEAD_W-1:0] tail_pos(input logic [HEAD_W-1:0] h,
                                                 input logic [FILL_W-1:0] f);
    logic [HEAD_W:0] sum;
    sum = (HEAD_W+1)'(h) + (HEAD_W+1)'(f);
    if (sum >= (HEAD_W+1)'(RING_DEPTH)) begin
      sum = sum - (HEAD_W+1)'(RING_DEPTH);
    end
    tail_pos = HEAD_W'(sum);
  endfunction

  msrf_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MEM_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(byte_r),
    .rdata(ram_rdata)
  );

  // accept only when idle and the result register is free or draining
  assign in_chan.ready = (state_r == S_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_take = out_valid_r && out_chan.ready;

  assign tr_ok = (32'(in_chan.transport) < SLOT_COUNT);
  assign sidx  = SLOT_W'(in_chan.transport);
  assign owns  = owner_valid_r && (owner_slot_r == sidx) && (owner_id_r == in_chan.session);

  always_comb begin
    state_nxt       = state_r;
    fan_idx_nxt     = fan_idx_r;
    byte_nxt        = byte_r;
    id_ctr_nxt      = id_ctr_r;
    owner_valid_nxt = owner_valid_r;
    owner_slot_nxt  = owner_slot_r;
    owner_id_nxt    = owner_id_r;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      slot_id_nxt[s] = slot_id_r[s];
      head_nxt[s]    = head_r[s];
      fill_nxt[s]    = fill_r[s];
      drop_nxt[s]    = drop_r[s];
    end
    ram_we   = 1'b0;
    ram_addr = '0;
    res      = '0;
    load_out = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          load_out = 1'b1;
          res.status_code = ST_OK;
          priority if (in_chan.op == OP_RX) begin
            // result is plain ok; ring writes follow one slot per cycle
            byte_nxt    = in_chan.rx_byte;
            fan_idx_nxt = '0;
            state_nxt   = S_FAN;
          end else if (in_chan.op > OP_STATUS || !tr_ok) begin
            res.status_code = ST_INVALID;
          end else if (in_chan.op == OP_OPEN) begin
            priority if (in_chan.transport == NET_SLOT && !in_chan.authenticated) begin
              res.status_code = ST_UNAUTH;
            end else if (slot_id_r[sidx] != '0) begin
              res.status_code = ST_BUSY;
            end else begin
              // the counter never hands out zero
              if (id_ctr_r == '0) begin
                res.granted_id = SESSION_W'(1);
                id_ctr_nxt     = SESSION_W'(2);
              end else begin
                res.granted_id = id_ctr_r;
                id_ctr_nxt     = id_ctr_r + SESSION_W'(1);
              end
              slot_id_nxt[sidx] = res.granted_id;
              head_nxt[sidx]    = '0;
              fill_nxt[sidx]    = '0;
              drop_nxt[sidx]    = '0;
            end
          end else if (in_chan.session == '0) begin
            res.status_code = ST_INVALID;
          end else if (slot_id_r[sidx] != in_chan.session) begin
            res.status_code = ST_STALE;
          end else begin
            unique case (in_chan.op)
              OP_CLOSE: begin
                if (owns) begin
                  owner_valid_nxt = 1'b0;
                  owner_slot_nxt  = '0;
                  owner_id_nxt    = '0;
                end
                slot_id_nxt[sidx] = '0;
                head_nxt[sidx]    = '0;
                fill_nxt[sidx]    = '0;
                drop_nxt[sidx]    = '0;
              end
              OP_READ: begin
                if (fill_r[sidx] != '0) begin
                  // pop now, the byte comes back from memory next cycle
                  ram_addr = ring_addr(sidx, head_r[sidx]);
                  if (32'(head_r[sidx]) == RING_DEPTH - 1) begin
                    head_nxt[sidx] = '0;
                  end else begin
                    head_nxt[sidx] = head_r[sidx] + HEAD_W'(1);
                  end
                  fill_nxt[sidx] = fill_r[sidx] - FILL_W'(1);
                  load_out  = 1'b0;
                  state_nxt = S_RDATA;
                end
              end
              OP_ACQ: begin
                priority if (!owner_valid_r) begin
                  owner_valid_nxt = 1'b1;
                  owner_slot_nxt  = sidx;
                  owner_id_nxt    = in_chan.session;
                end else if (owns) begin
                  res.status_code = ST_OWNER;
                end else begin
                  res.status_code = ST_BUSY;
                end
              end
              OP_STATUS: begin
                res.buffered_count = COUNT_W'(fill_r[sidx]);
                res.dropped_count  = drop_r[sidx];
                res.is_tx_owner    = owns;
              end
              default: begin
                res.status_code = ST_INVALID;
              end
            endcase
          end
        end
      end

      S_FAN: begin
        // one slot per cycle: append or count a drop
        if (slot_id_r[fan_idx_r] != '0) begin
          if (32'(fill_r[fan_idx_r]) < RING_DEPTH) begin
            ram_we   = 1'b1;
            ram_addr = ring_addr(fan_idx_r, tail_pos(head_r[fan_idx_r], fill_r[fan_idx_r]));
            fill_nxt[fan_idx_r] = fill_r[fan_idx_r] + FILL_W'(1);
          end else if (drop_r[fan_idx_r] != '1) begin
            drop_nxt[fan_idx_r] = drop_r[fan_idx_r] + DROP_W'(1);
          end
        end
        if (32'(fan_idx_r) == SLOT_COUNT - 1) begin
          state_nxt = S_IDLE;
        end else begin
          fan_idx_nxt = fan_idx_r + SLOT_W'(1);
        end
      end

      S_RDATA: begin
        res.status_code = ST_OK;
        res.data_byte   = ram_rdata;
        res.data_valid  = 1'b1;
        load_out  = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // result register: load a new result or drain the old one
    if (load_out) begin
      out_valid_nxt = 1'b1;
      res_nxt       = res;
    end else begin
      out_valid_nxt = out_take ? 1'b0 : out_valid_r;
      res_nxt       = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      fan_idx_r     <= '0;
      id_ctr_r      <= SESSION_W'(1);
      owner_valid_r <= 1'b0;
      owner_slot_r  <= '0;
      owner_id_r    <= '0;
      out_valid_r   <= 1'b0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        slot_id_r[s] <= '0;
        head_r[s]    <= '0;
        fill_r[s]    <= '0;
        drop_r[s]    <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      fan_idx_r     <= fan_idx_nxt;
      id_ctr_r      <= id_ctr_nxt;
      owner_valid_r <= owner_valid_nxt;
      owner_slot_r  <= owner_slot_nxt;
      owner_id_r    <= owner_id_nxt;
      out_valid_r   <= out_valid_nxt;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        slot_id_r[s] <= slot_id_nxt[s];
        head_r[s]    <= head_nxt[s];
        fill_r[s]    <= fill_nxt[s];
        drop_r[s]    <= drop_nxt[s];
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    res_r  <= res_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status_code    = res_r.status_code;
  assign out_chan.granted_id     = res_r.granted_id;
  assign out_chan.data_byte      = res_r.data_byte;
  assign out_chan.data_valid     = res_r.data_valid;
  assign out_chan.buffered_count = res_r.buffered_count;
  assign out_chan.dropped_count  = res_r.dropped_count;
  assign out_chan.is_tx_owner    = res_r.is_tx_owner;

endmodule

### dv/multi_subscriber_rx_fanout_buffer_tb.sv
// testbench for the rx fanout buffer: directed and random session traffic against a predictor
`timescale 1ns / 100ps

module multi_subscriber_rx_fanout_buffer_tb;
  import msrf_pkg::*;

  // ops outside the defined set
  localparam logic [OP_W-1:0] OP_BAD_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_BAD_HI = 3'd7;
  // transport indexes
  localparam logic [TRANS_W-1:0] USB_SLOT = 2'd0;
  localparam logic [TRANS_W-1:0] BAD_SLOT = 2'd3;
  localparam logic [TRANS_W-1:0] BAD_SLOT_LO = 2'd2;

  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_CYCLES = 10;       // slowest op is the rx byte, which visits every slot
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [TRANS_W-1:0]   transport;
    logic [SESSION_W-1:0] session;
    logic                 authenticated;
    logic [BYTE_W-1:0]    rx_byte;
  } req_t;

  logic clk;
  logic rst_n;

  msrf_in_if  req_if ();
  msrf_out_if res_if ();

  multi_subscriber_rx_fanout_buffer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (res_if)
  );

  // predicted block state, updated once per accepted request transaction
  logic [SESSION_W-1:0] open_sid  [SLOT_COUNT_DEF];
  logic [BYTE_W-1:0]    ring_data [SLOT_COUNT_DEF][RING_DEPTH_DEF];
  int                   ring_rd   [SLOT_COUNT_DEF];
  logic [COUNT_W-1:0]   ring_cnt  [SLOT_COUNT_DEF];
  logic [DROP_W-1:0]    lost_cnt  [SLOT_COUNT_DEF];
  logic [SESSION_W-1:0] next_sid;
  logic                 tx_held;
  int                   tx_slot;
  logic [SESSION_W-1:0] tx_sid;

  result_t pending_results [$];   // results still owed by the block, oldest first
  result_t want;
  int      err_count;
  int      burst_left;
  int      cycle_count;
  logic [15:0] ready_mask;
  int          ready_phase;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** multi_subscriber_rx_fanout_buffer: FAILED **");
    $finish;
  end

  function automatic void clear_slot_state(int s);
    open_sid[s] = '0;
    ring_rd[s]  = 0;
    ring_cnt[s] = '0;
    lost_cnt[s] = '0;
  endfunction

  function automatic void reset_prediction();
    int s;
    for (s = 0; s < SLOT_COUNT_DEF; s++) clear_slot_state(s);
    next_sid = 32'd1;
    tx_held  = 1'b0;
    tx_slot  = 0;
    tx_sid   = '0;
  endfunction

  function automatic logic holds_tx(int s, logic [SESSION_W-1:0] sid);
    return tx_held && tx_slot == s && tx_sid == sid;
  endfunction

  // compute the result of one request and advance the predicted state
  function automatic result_t apply_request(req_t r);
    result_t res;
    int      s;
    int      tr;
    res = '0;
    res.status_code = ST_OK;
    tr = int'(r.transport);
    if (r.op == OP_RX) begin
      // fan the byte out to every open slot, count it as lost where the ring is full
      for (s = 0; s < SLOT_COUNT_DEF; s++) begin
        if (open_sid[s] != '0) begin
          if (ring_cnt[s] < RING_DEPTH_DEF) begin
            ring_data[s][(ring_rd[s] + int'(ring_cnt[s])) % RING_DEPTH_DEF] = r.rx_byte;
            ring_cnt[s] = ring_cnt[s] + 1'b1;
          end else if (lost_cnt[s] != '1) begin
            lost_cnt[s] = lost_cnt[s] + 1'b1;
          end
        end
      end
    end else if (r.op == OP_BAD_LO || r.op == OP_BAD_HI || tr >= SLOT_COUNT_DEF) begin
      res.status_code = ST_INVALID;
    end else if (r.op == OP_OPEN) begin
      if (r.transport == NET_SLOT && !r.authenticated) begin
        res.status_code = ST_UNAUTH;
      end else if (open_sid[tr] != '0) begin
        res.status_code = ST_BUSY;
      end else begin
        // id counter wraps and never hands out zero
        if (next_sid == '0) next_sid = 32'd1;
        clear_slot_state(tr);
        open_sid[tr] = next_sid;
        res.granted_id = next_sid;
        next_sid = next_sid + 1'b1;
      end
    end else if (r.session == '0) begin
      res.status_code = ST_INVALID;
    end else if (open_sid[tr] != r.session) begin
      res.status_code = ST_STALE;
    end else if (r.op == OP_CLOSE) begin
      if (holds_tx(tr, r.session)) begin
        tx_held = 1'b0;
        tx_slot = 0;
        tx_sid  = '0;
      end
      clear_slot_state(tr);
    end else if (r.op == OP_READ) begin
      if (ring_cnt[tr] != '0) begin
        res.data_byte  = ring_data[tr][ring_rd[tr]];
        res.data_valid = 1'b1;
        ring_rd[tr]    = (ring_rd[tr] + 1) % RING_DEPTH_DEF;
        ring_cnt[tr]   = ring_cnt[tr] - 1'b1;
      end
    end else if (r.op == OP_ACQ) begin
      if (!tx_held) begin
        tx_held = 1'b1;
        tx_slot = tr;
        tx_sid  = r.session;
      end else if (holds_tx(tr, r.session)) begin
        res.status_code = ST_OWNER;
      end else begin
        res.status_code = ST_BUSY;
      end
    end else begin
      res.buffered_count = ring_cnt[tr];
      res.dropped_count  = lost_cnt[tr];
      res.is_tx_owner    = holds_tx(tr, r.session);
    end
    return res;
  endfunction

  function automatic req_t mk_req(logic [OP_W-1:0] op, logic [TRANS_W-1:0] tr,
                                  logic [SESSION_W-1:0] sid, logic auth,
                                  logic [BYTE_W-1:0] b);
    req_t r;
    r.op            = op;
    r.transport     = tr;
    r.session       = sid;
    r.authenticated = auth;
    r.rx_byte       = b;
    return r;
  endfunction

  // drive one request transaction; the sender runs in bursts with random gaps between
  task automatic send_req(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      @(negedge clk);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    req_if.valid         <= 1'b1;
    req_if.op            <= r.op;
    req_if.transport     <= r.transport;
    req_if.session       <= r.session;
    req_if.authenticated <= r.authenticated;
    req_if.rx_byte       <= r.rx_byte;
    do @(posedge clk); while (!req_if.ready);
    pending_results.push_back(apply_request(r));
  endtask

  // take valid down and wait until every owed result has come back
  task automatic drain_results();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver stalls on a rotating mask, regenerated each time the phase counter wraps
  always @(negedge clk) begin
    if (ready_phase == 0) begin
      if ($urandom_range(0, 3) == 0) ready_mask = '1;
      else ready_mask = 16'($urandom) | 16'($urandom);
      if (ready_mask == '0) ready_mask = 16'd1;
    end
    res_if.ready <= ready_mask[ready_phase % 16];
    ready_phase = (ready_phase + 1) % 64;
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  // compare each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing outstanding: status_code %0d",
               res_if.status_code);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status_code", 32'(want.status_code), 32'(res_if.status_code));
        check_field("granted_id", want.granted_id, res_if.granted_id);
        check_field("data_byte", 32'(want.data_byte), 32'(res_if.data_byte));
        check_field("data_valid", 32'(want.data_valid), 32'(res_if.data_valid));
        check_field("buffered_count", 32'(want.buffered_count), 32'(res_if.buffered_count));
        check_field("dropped_count", want.dropped_count, res_if.dropped_count);
        check_field("is_tx_owner", 32'(want.is_tx_owner), 32'(res_if.is_tx_owner));
      end
    end
  end

  // errors out of reset: nothing open yet
  task automatic test_idle_errors();
    send_req(mk_req(OP_RX, USB_SLOT, '0, 1'b0, 8'h00));           // byte with no open slot
    send_req(mk_req(OP_STATUS, USB_SLOT, '1, 1'b1, 8'hFF));       // stale id on closed slot
    send_req(mk_req(OP_READ, NET_SLOT, '0, 1'b0, 8'h00));         // zero session
    send_req(mk_req(OP_BAD_LO, USB_SLOT, 32'd1, 1'b1, 8'h00));
    send_req(mk_req(OP_BAD_HI, NET_SLOT, 32'd1, 1'b1, 8'h00));
    send_req(mk_req(OP_OPEN, BAD_SLOT, '0, 1'b1, 8'h00));         // transport out of range
    send_req(mk_req(OP_ACQ, BAD_SLOT_LO, 32'd1, 1'b1, 8'h00));
  endtask

  task automatic test_open_close();
    send_req(mk_req(OP_OPEN, NET_SLOT, '0, 1'b0, 8'h00));         // network needs auth
    send_req(mk_req(OP_OPEN, USB_SLOT, '0, 1'b0, 8'h00));
    send_req(mk_req(OP_OPEN, NET_SLOT, '0, 1'b1, 8'h00));
    send_req(mk_req(OP_OPEN, USB_SLOT, '1, 1'b1, 8'h00));         // occupied slot
    send_req(mk_req(OP_CLOSE, USB_SLOT, open_sid[0] + 1'b1, 1'b1, 8'h00));
  endtask

  // bytes land in both rings; read the usb ring back until empty
  task automatic test_fanout_read();
    send_req(mk_req(OP_RX, USB_SLOT, '0, 1'b0, 8'hFF));
    send_req(mk_req(OP_RX, BAD_SLOT, '1, 1'b1, 8'hA5));
    send_req(mk_req(OP_READ, USB_SLOT, open_sid[0], 1'b0, 8'h00));
    send_req(mk_req(OP_READ, USB_SLOT, open_sid[0], 1'b0, 8'h00));
    send_req(mk_req(OP_READ, USB_SLOT, open_sid[0], 1'b0, 8'h00)); // empty ring
    send_req(mk_req(OP_STATUS, NET_SLOT, open_sid[1], 1'b0, 8'h00));
  endtask

  task automatic test_tx_owner();
    send_req(mk_req(OP_ACQ, USB_SLOT, open_sid[0], 1'b0, 8'h00));
    send_req(mk_req(OP_ACQ, USB_SLOT, open_sid[0], 1'b0, 8'h00)); // already owner
    send_req(mk_req(OP_ACQ, NET_SLOT, open_sid[1], 1'b0, 8'h00)); // held by the other one
    send_req(mk_req(OP_STATUS, USB_SLOT, open_sid[0], 1'b0, 8'h00));
    send_req(mk_req(OP_CLOSE, USB_SLOT, open_sid[0], 1'b0, 8'h00)); // close drops ownership
    send_req(mk_req(OP_ACQ, NET_SLOT, open_sid[1], 1'b0, 8'h00));
    send_req(mk_req(OP_STATUS, NET_SLOT, open_sid[1], 1'b0, 8'h00));
  endtask

  // fill both rings past capacity so the drop counters move
  task automatic test_ring_overflow();
    int i;
    send_req(mk_req(OP_OPEN, USB_SLOT, '0, 1'b0, 8'h00));
    for (i = 0; i < RING_DEPTH_DEF + 6; i++)
      send_req(mk_req(OP_RX, 2'($urandom), $urandom, 1'($urandom), 8'($urandom)));
    send_req(mk_req(OP_STATUS, USB_SLOT, open_sid[0], 1'b0, 8'h00));
    send_req(mk_req(OP_STATUS, NET_SLOT, open_sid[1], 1'b0, 8'h00));
    send_req(mk_req(OP_READ, NET_SLOT, open_sid[1], 1'b0, 8'h00));
    send_req(mk_req(OP_READ, NET_SLOT, open_sid[1], 1'b0, 8'h00));
    send_req(mk_req(OP_RX, USB_SLOT, '0, 1'b0, 8'h5A));           // stored on net, lost on usb
    send_req(mk_req(OP_STATUS, USB_SLOT, open_sid[0], 1'b0, 8'h00));
    send_req(mk_req(OP_STATUS, NET_SLOT, open_sid[1], 1'b0, 8'h00));
    send_req(mk_req(OP_CLOSE, USB_SLOT, open_sid[0], 1'b0, 8'h00));
    send_req(mk_req(OP_CLOSE, NET_SLOT, open_sid[1], 1'b0, 8'h00)); // owner closes
  endtask

  // mostly the live id of the addressed slot, otherwise a wrong one
  function automatic logic [SESSION_W-1:0] pick_session(logic [TRANS_W-1:0] tr);
    int roll;
    roll = $urandom_range(0, 99);
    if (int'(tr) >= SLOT_COUNT_DEF) return $urandom;
    if (roll < 72) return open_sid[tr];
    if (roll < 82) return open_sid[SLOT_COUNT_DEF - 1 - int'(tr)];
    if (roll < 87) return '0;
    if (roll < 92) return open_sid[tr] + 1'b1;
    return $urandom;
  endfunction

  task automatic test_random_traffic();
    int   i;
    int   roll;
    req_t r;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) r.op = OP_RX;
      else if (roll < 55) r.op = OP_READ;
      else if (roll < 65) r.op = OP_OPEN;
      else if (roll < 71) r.op = OP_CLOSE;
      else if (roll < 80) r.op = OP_ACQ;
      else if (roll < 96) r.op = OP_STATUS;
      else r.op = ($urandom_range(0, 1) == 0) ? OP_BAD_LO : OP_BAD_HI;
      r.transport     = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                                    : 2'($urandom_range(0, 1));
      r.session       = pick_session(r.transport);
      r.authenticated = ($urandom_range(0, 6) != 0);
      r.rx_byte       = 8'($urandom);
      send_req(r);
    end
  endtask

  initial begin
    // every block input known from time zero
    rst_n                = 1'b0;
    req_if.valid         = 1'b0;
    req_if.op            = OP_RX;
    req_if.transport     = USB_SLOT;
    req_if.session       = '0;
    req_if.authenticated = 1'b0;
    req_if.rx_byte       = '0;
    res_if.ready         = 1'b0;
    ready_mask           = '1;
    ready_phase          = 0;
    err_count            = 0;
    burst_left           = 0;
    reset_prediction();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_errors();
    test_open_close();
    test_fanout_read();
    test_tx_owner();
    test_ring_overflow();
    test_random_traffic();
    drain_results();

    if (err_count == 0) begin
      $display("** multi_subscriber_rx_fanout_buffer: PASSED **");
    end else begin
      $display("** multi_subscriber_rx_fanout_buffer: FAILED **");
    end
    $finish;
  end

endmodule
